// ===== rtl/lrqe_pkg.sv =====
`default_nettype none
package lrqe_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic        [31:0] arc_len;
      logic               line_first;
   } req_type;

   typedef struct packed {
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic signed [15:0] tan_x;
      logic signed [15:0] tan_y;
      logic signed [15:0] tan_z;
      logic        [31:0] vert_arc;
      logic               side_positive;
      logic               run_last;
   } rsp_type;

   // one segment handed from the front to the back
   typedef struct packed {
      logic signed [31:0] prev_x;
      logic signed [31:0] prev_y;
      logic signed [31:0] prev_z;
      logic        [31:0] prev_arc;
      logic signed [31:0] cur_x;
      logic signed [31:0] cur_y;
      logic signed [31:0] cur_z;
      logic        [31:0] cur_arc;
      logic signed [32:0] d_x;
      logic signed [32:0] d_y;
      logic signed [32:0] d_z;
   } job_type;

   typedef struct packed {
      logic                full;
      logic [QUEUE_CW-1:0] count;
   } queue_status_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SHIFT,
      B_SQUARE,
      B_SQRT,
      B_CHECK,
      B_DIV,
      B_EMIT
   } back_state_type;

   // corner per vertex: bit 1 = current sample, bit 0 = positive side
   function automatic logic [1:0] corner_of(input logic [2:0] idx);
      logic [1:0] c;
      case (idx)
         3'd0:    c = 2'd0;
         3'd1:    c = 2'd1;
         3'd2:    c = 2'd2;
         3'd3:    c = 2'd1;
         3'd4:    c = 2'd3;
         3'd5:    c = 2'd2;
         default: c = 2'd0;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/lrqe_front.sv =====
`default_nettype none
module lrqe_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  lrqe_pkg::req_type            req_data,
   input  lrqe_pkg::queue_status_type   q_status,
   output logic                         push,
   output lrqe_pkg::job_type            push_job
);
   import lrqe_pkg::*;

   logic signed [31:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic        [31:0] prev_arc_ff;
   logic               have_prev_ff;
   logic               accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   // a segment exists only when a previous sample is held on the same line
   assign push      = accept && !req_data.line_first && have_prev_ff;

   always_comb begin
      push_job.prev_x   = prev_x_ff;
      push_job.prev_y   = prev_y_ff;
      push_job.prev_z   = prev_z_ff;
      push_job.prev_arc = prev_arc_ff;
      push_job.cur_x    = req_data.pos_x;
      push_job.cur_y    = req_data.pos_y;
      push_job.cur_z    = req_data.pos_z;
      push_job.cur_arc  = req_data.arc_len;
      push_job.d_x      = 33'(req_data.pos_x) - 33'(prev_x_ff);
      push_job.d_y      = 33'(req_data.pos_y) - 33'(prev_y_ff);
      push_job.d_z      = 33'(req_data.pos_z) - 33'(prev_z_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
         prev_arc_ff  <= '0;
      end else if (accept) begin
         have_prev_ff <= 1'b1;
         prev_x_ff    <= req_data.pos_x;
         prev_y_ff    <= req_data.pos_y;
         prev_z_ff    <= req_data.pos_z;
         prev_arc_ff  <= req_data.arc_len;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/lrqe_queue.sv =====
`default_nettype none
module lrqe_queue (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  lrqe_pkg::job_type            push_job,
   input  wire                          pop,
   output logic                         job_valid,
   output lrqe_pkg::job_type            job,
   output lrqe_pkg::queue_status_type   q_status
);
   import lrqe_pkg::*;

   localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   job_type             mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CW-1:0] count_ff;
   logic                do_pop;

   assign job_valid      = count_ff != '0;
   assign job            = mem_ff[rd_ptr_ff];
   assign q_status.full  = count_ff == QUEUE_CW'(QUEUE_DEPTH);
   assign q_status.count = count_ff;
   assign do_pop         = pop && job_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QUEUE_CW'(push) - QUEUE_CW'(do_pop);
      end
   end

endmodule
`default_nettype wire

// ===== rtl/lrqe_back.sv =====
`default_nettype none
module lrqe_back #(
   parameter int unsigned TANGENT_FRAC_BITS = 14
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire  [15:0]           min_len,
   input  wire                   job_valid,
   input  lrqe_pkg::job_type     job,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output lrqe_pkg::rsp_type     rsp_data
);
   import lrqe_pkg::*;

   localparam int unsigned F  = TANGENT_FRAC_BITS;
   localparam int unsigned QW = F + 1;
   localparam int unsigned NW = 32 + F;

   back_state_type state_ff, state_in;

   job_type            job_ff;
   logic [32:0]        abs_ff [3];
   logic [30:0]        mag_ff [3];
   logic [2:0]         neg_ff;
   logic               snz_ff;
   logic [1:0]         k_ff;
   logic [61:0]        prod_ff;
   logic [63:0]        acc_ff;
   logic [63:0]        rad_ff;
   logic [31:0]        root_ff;
   logic [32:0]        srem_ff;
   logic [4:0]         cnt_ff;
   logic [31:0]        drem_ff;
   logic [F:0]         num_ff;
   logic [QW-1:0]      quo_ff;
   logic signed [15:0] tan_ff [3];
   logic [2:0]         vidx_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               any31, any32, out_free, sqrt_done, div_done, skip;
   logic [30:0]        mul_a, ld_mag;
   logic [61:0]        sq;
   logic [1:0]         ld_sel;
   logic [34:0]        s_sh, s_trial;
   logic [NW-1:0]      ld_num;
   logic [32:0]        d_sh;
   logic               d_bit;
   logic [QW-1:0]      q_fin;
   logic [31:0]        t32;
   logic signed [15:0] t_sat;
   logic [1:0]         corner;
   rsp_type            vert;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pop       = (state_ff == B_IDLE) && job_valid;

   assign any31 = abs_ff[0][31] | abs_ff[1][31] | abs_ff[2][31];
   assign any32 = abs_ff[0][32] | abs_ff[1][32] | abs_ff[2][32];

   assign sqrt_done = cnt_ff == 5'd31;
   assign div_done  = cnt_ff == 5'(F);
   assign skip      = (root_ff == '0) || (!snz_ff && (root_ff < {16'd0, min_len}));

   always_comb begin
      case (k_ff)
         2'd0:    mul_a = mag_ff[0];
         2'd1:    mul_a = mag_ff[1];
         2'd2:    mul_a = mag_ff[2];
         default: mul_a = '0;
      endcase
   end

   // full 62 bit square of one magnitude
   assign sq = mul_a * mul_a;

   // square root: two radicand bits per step
   assign s_sh    = {srem_ff, rad_ff[63:62]};
   assign s_trial = {1'b0, root_ff, 2'b01};

   // divider load: quotient is below 2^(F+1), so the top part is already below the length
   assign ld_sel = (state_ff == B_CHECK) ? 2'd0 : k_ff + 2'd1;
   always_comb begin
      case (ld_sel)
         2'd0:    ld_mag = mag_ff[0];
         2'd1:    ld_mag = mag_ff[1];
         2'd2:    ld_mag = mag_ff[2];
         default: ld_mag = '0;
      endcase
   end
   assign ld_num = {1'b0, ld_mag, F'(0)} + NW'(root_ff >> 1);

   assign d_sh  = {drem_ff, num_ff[F]};
   assign d_bit = d_sh >= {1'b0, root_ff};
   assign q_fin = {quo_ff[QW-2:0], d_bit};
   assign t32   = 32'(q_fin);

   // saturate to the field
   always_comb begin
      if (neg_ff[k_ff]) begin
         t_sat = (t32 > 32'd32768) ? 16'sh8000 : 16'(32'd0 - t32);
      end else begin
         t_sat = (t32 > 32'd32767) ? 16'sh7FFF : 16'(t32);
      end
   end

   assign corner = corner_of(vidx_ff);
   always_comb begin
      vert.vert_x        = corner[1] ? job_ff.cur_x   : job_ff.prev_x;
      vert.vert_y        = corner[1] ? job_ff.cur_y   : job_ff.prev_y;
      vert.vert_z        = corner[1] ? job_ff.cur_z   : job_ff.prev_z;
      vert.vert_arc      = corner[1] ? job_ff.cur_arc : job_ff.prev_arc;
      vert.tan_x         = tan_ff[0];
      vert.tan_y         = tan_ff[1];
      vert.tan_z         = tan_ff[2];
      vert.side_positive = corner[0];
      vert.run_last      = vidx_ff == 3'd5;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:   if (job_valid) state_in = B_SHIFT;
         B_SHIFT:  state_in = B_SQUARE;
         B_SQUARE: if (k_ff == 2'd3) state_in = B_SQRT;
         B_SQRT:   if (sqrt_done) state_in = B_CHECK;
         B_CHECK:  state_in = skip ? B_IDLE : B_DIV;
         B_DIV:    if (div_done && k_ff == 2'd2) state_in = B_EMIT;
         B_EMIT:   if (out_free && vidx_ff == 3'd5) state_in = B_IDLE;
         default:  state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            job_ff    <= job;
            neg_ff    <= {job.d_z[32], job.d_y[32], job.d_x[32]};
            abs_ff[0] <= job.d_x[32] ? 33'(-job.d_x) : 33'(job.d_x);
            abs_ff[1] <= job.d_y[32] ? 33'(-job.d_y) : 33'(job.d_y);
            abs_ff[2] <= job.d_z[32] ? 33'(-job.d_z) : 33'(job.d_z);
         end
         B_SHIFT: begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= any32 ? 31'(abs_ff[i] >> 2) :
                            any31 ? 31'(abs_ff[i] >> 1) : abs_ff[i][30:0];
            end
            snz_ff  <= any31 | any32;
            k_ff    <= '0;
            acc_ff  <= '0;
            prod_ff <= '0;
         end
         B_SQUARE: begin
            if (k_ff == 2'd3) begin
               rad_ff  <= acc_ff + 64'(prod_ff);
               root_ff <= '0;
               srem_ff <= '0;
               cnt_ff  <= '0;
            end else begin
               acc_ff  <= acc_ff + 64'(prod_ff);
               prod_ff <= sq;
               k_ff    <= k_ff + 2'd1;
            end
         end
         B_SQRT: begin
            rad_ff <= {rad_ff[61:0], 2'b00};
            cnt_ff <= cnt_ff + 5'd1;
            if (s_sh >= s_trial) begin
               srem_ff <= 33'(s_sh - s_trial);
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               srem_ff <= s_sh[32:0];
               root_ff <= {root_ff[30:0], 1'b0};
            end
         end
         B_CHECK: begin
            k_ff    <= '0;
            cnt_ff  <= '0;
            drem_ff <= 32'(ld_num[NW-1:F+1]);
            num_ff  <= ld_num[F:0];
            quo_ff  <= '0;
         end
         B_DIV: begin
            if (div_done) begin
               tan_ff[k_ff] <= t_sat;
               k_ff    <= k_ff + 2'd1;
               cnt_ff  <= '0;
               drem_ff <= 32'(ld_num[NW-1:F+1]);
               num_ff  <= ld_num[F:0];
               quo_ff  <= '0;
               vidx_ff <= '0;
            end else begin
               cnt_ff  <= cnt_ff + 5'd1;
               drem_ff <= d_bit ? 32'(d_sh - {1'b0, root_ff}) : d_sh[31:0];
               num_ff  <= {num_ff[F-1:0], 1'b0};
               quo_ff  <= q_fin;
            end
         end
         B_EMIT: begin
            if (out_free) begin
               vidx_ff <= vidx_ff + 3'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= state_ff == B_EMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && state_ff == B_EMIT) begin
         rsp_ff <= vert;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/line_ribbon_quad_expander_top.sv =====
`default_nettype none
// Line ribbon quad expander. Takes polyline samples (Q16.16 position, arc
// length, first-of-line flag) and, for every segment from the previous sample
// to the current one that is nonzero and at least csr_wdata's programmed
// minimum long, emits six ribbon vertices (triangles 0-1-2 and 1-3-2) carrying
// the unit tangent with TANGENT_FRAC_BITS fraction bits. The front takes one
// item per cycle into a two-entry queue while it has room; the back works on
// one segment at a time through the 32-step square root and the shared
// bit-serial divider, and holds while the result side stalls. First samples
// never reach the back; short segments pass through it and emit nothing.
module line_ribbon_quad_expander_top #(
   parameter int unsigned TANGENT_FRAC_BITS = 14
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  lrqe_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output lrqe_pkg::rsp_type   rsp_data,
   input  wire                 csr_we,
   input  wire  [15:0]         csr_wdata
);
   import lrqe_pkg::*;

   logic [15:0]      min_len_ff;
   logic             push, pop, job_valid;
   job_type          push_job, job;
   queue_status_type q_status;

   // minimum segment length register, reset to one unit
   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= 16'd1;
      end else if (csr_we) begin
         min_len_ff <= csr_wdata;
      end
   end

   // front: hold the previous sample, form the difference vector
   lrqe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_job  (push_job)
   );

   lrqe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .job_valid (job_valid),
      .job       (job),
      .q_status  (q_status)
   );

   // back: length, skip test, tangent, vertex emission
   lrqe_back #(
      .TANGENT_FRAC_BITS (TANGENT_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .min_len   (min_len_ff),
      .job_valid (job_valid),
      .job       (job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // the closing vertex of a segment is always on the negative side
   a_last_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.run_last |-> !rsp_data.side_positive)
      else $error("last vertex not on negative side");

   // the queue never holds more than its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QUEUE_CW'(QUEUE_DEPTH))
      else $error("queue overfilled");

   // no push is taken into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("push into full queue");

   // a register write lands on the next cycle
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> min_len_ff == $past(csr_wdata))
      else $error("minimum length write lost");
`endif

endmodule
`default_nettype wire

// ===== sim/line_ribbon_quad_expander_checker.sv =====
module line_ribbon_quad_expander_checker (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire                 req_stall,
   input  lrqe_pkg::req_type   req_data,
   input  wire                 rsp_valid,
   input  wire                 rsp_stall,
   input  lrqe_pkg::rsp_type   rsp_data,
   input  wire                 csr_we,
   input  wire [15:0]          csr_wdata,
   output int                  fail_count,
   output int                  pending,
   output int                  vertex_count,
   output int                  segment_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import lrqe_pkg::*;

   localparam int FRAC = 14;

   rsp_type     vertex_queue[$];
   logic [15:0] min_len;
   logic [31:0] last_x, last_y, last_z, last_arc;
   logic        last_valid;

   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] unit_component(input logic neg, input logic [63:0] mag,
                                                  input logic [63:0] len);
      logic [63:0] t;
      t = ((mag << FRAC) + (len >> 1)) / len;
      if (neg) begin
         if (t > 64'd32768) t = 64'd32768;
         return 16'(-t);
      end
      if (t > 64'd32767) t = 64'd32767;
      return t[15:0];
   endfunction

   // expand one accepted sample into its ribbon vertices, then advance the held sample
   task automatic expand_sample(input req_type r);
      logic signed [63:0] d[3];
      logic [63:0] mag[3], big, sum, len;
      logic [15:0] t[3];
      logic [1:0]  c;
      int          s;
      rsp_type     v;
      if (!r.line_first && last_valid) begin
         d[0] = 64'(r.pos_x) - 64'($signed(last_x));
         d[1] = 64'(r.pos_y) - 64'($signed(last_y));
         d[2] = 64'(r.pos_z) - 64'($signed(last_z));
         big = 0;
         for (int k = 0; k < 3; k++) begin
            mag[k] = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
            if (mag[k] > big) big = mag[k];
         end
         s = 0;
         while ((big >> s) >= 64'h8000_0000) s++;
         sum = 0;
         for (int k = 0; k < 3; k++) begin
            mag[k] = mag[k] >> s;
            sum = sum + mag[k] * mag[k];
         end
         len = root64(sum);
         if (len != 0 && (s != 0 || len >= 64'(min_len))) begin
            for (int k = 0; k < 3; k++) t[k] = unit_component(d[k] < 0, mag[k], len);
            for (int k = 0; k < 6; k++) begin
               c = corner_of(3'(k));
               v.vert_x = c[1] ? r.pos_x : last_x;
               v.vert_y = c[1] ? r.pos_y : last_y;
               v.vert_z = c[1] ? r.pos_z : last_z;
               v.tan_x = t[0];
               v.tan_y = t[1];
               v.tan_z = t[2];
               v.vert_arc = c[1] ? r.arc_len : last_arc;
               v.side_positive = c[0];
               v.run_last = (k == 5);
               vertex_queue = {vertex_queue, v};
            end
            segment_count++;
         end
      end
      last_x = r.pos_x;
      last_y = r.pos_y;
      last_z = r.pos_z;
      last_arc = r.arc_len;
      last_valid = 1'b1;
   endtask

   task automatic compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, got %h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      vertex_count = 0;
      segment_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         vertex_queue.delete();
         min_len = 16'd1;
         last_valid = 1'b0;
         last_x = 0; last_y = 0; last_z = 0; last_arc = 0;
      end else begin
         if (csr_we) min_len = csr_wdata;
         if (req_valid && !req_stall) expand_sample(req_data);
         if (rsp_valid && !rsp_stall) begin
            vertex_count++;
            if (vertex_queue.size() == 0) begin
               $error("unexpected vertex %p", rsp_data);
               fail_count++;
            end else begin
               e = vertex_queue.pop_front();
               compare_field("vert_x", e.vert_x, rsp_data.vert_x);
               compare_field("vert_y", e.vert_y, rsp_data.vert_y);
               compare_field("vert_z", e.vert_z, rsp_data.vert_z);
               compare_field("tan_x", 32'(e.tan_x), 32'(rsp_data.tan_x));
               compare_field("tan_y", 32'(e.tan_y), 32'(rsp_data.tan_y));
               compare_field("tan_z", 32'(e.tan_z), 32'(rsp_data.tan_z));
               compare_field("vert_arc", e.vert_arc, rsp_data.vert_arc);
               compare_field("side_positive", 32'(e.side_positive),
                             32'(rsp_data.side_positive));
               compare_field("run_last", 32'(e.run_last), 32'(rsp_data.run_last));
            end
         end
      end
      pending = vertex_queue.size();
   end
endmodule

// ===== sim/line_ribbon_quad_expander_top_test.sv =====
module line_ribbon_quad_expander_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lrqe_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = 16'd0;

   int fail_count, pending, vertex_count, segment_count;
   int idle_cycles = 0;
   int sample_count = 0;
   bit holdoff_done = 1'b0;
   bit calm_stretch = 1'b0;
   bit stimulus_done = 1'b0;

   // the last position offered, so that random walks stay near it
   logic signed [31:0] walk_x = 0, walk_y = 0, walk_z = 0;
   logic        [31:0] walk_arc = 0;

   always #4 clock = ~clock;

   line_ribbon_quad_expander_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   line_ribbon_quad_expander_checker vertex_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .vertex_count  (vertex_count),
      .segment_count (segment_count)
   );

   // Watchdog: count cycles with no handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress after %0d cycles", idle_cycles);
         $display("line_ribbon_quad_expander_top verification failed");
         $finish;
      end
   end

   // Receiver: random stall, one long hold-off early on to back the block up, and
   // no stalling at all during the calm stretch.
   initial begin
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!holdoff_done && sample_count >= 30) begin
            holdoff_done = 1'b1;
            rsp_stall <= 1'b1;
            hold = 0;
            while (hold < 400) begin
               @(negedge clock);
               hold++;
            end
         end
         rsp_stall <= !calm_stretch && ($urandom_range(99) < 28);
         @(negedge clock);
      end
   end

   // Offer one sample; hold it until accepted. Idle between items at random outside
   // the calm stretch. Valid is left high on return; an idle, a settle or the end drops it.
   task automatic offer_sample(input req_type r);
      if (!calm_stretch) begin
         while ($urandom_range(99) < 28) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sample_count++;
   endtask

   task automatic offer_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [31:0] arc,
                              input logic first);
      req_type r;
      r.pos_x = x; r.pos_y = y; r.pos_z = z;
      r.arc_len = arc; r.line_first = first;
      offer_sample(r);
   endtask

   // Wait until every vertex has come out, then let the back finish any
   // segment that emits nothing before touching the register.
   task automatic settle_block();
      int n;
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      for (n = 0; n < 120; n++) @(negedge clock);
   endtask

   task automatic write_min_length(input logic [15:0] v);
      settle_block();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Random sample: short walks so segments vary around the minimum, as many
   // medium jumps, and sometimes full-range jumps, line starts and exact repeats.
   task automatic random_sample();
      int pick;
      logic signed [31:0] step;
      logic first;
      pick = $urandom_range(99);
      first = ($urandom_range(99) < 8);
      if (pick < 15) begin
         walk_x = $urandom; walk_y = $urandom; walk_z = $urandom;
      end else if (pick < 20) begin
         // repeat the held point: zero length
      end else if (pick < 60) begin
         step = $urandom_range(255); walk_x = walk_x + step - 128;
         step = $urandom_range(255); walk_y = walk_y + step - 128;
         step = $urandom_range(255); walk_z = walk_z + step - 128;
      end else begin
         walk_x = walk_x + $signed($urandom_range(2000000)) - 1000000;
         walk_y = walk_y + $signed($urandom_range(2000000)) - 1000000;
         walk_z = walk_z + $signed($urandom_range(2000000)) - 1000000;
      end
      walk_arc = ($urandom_range(9) == 0) ? $urandom : walk_arc + $urandom_range(65535);
      offer_point(walk_x, walk_y, walk_z, walk_arc, first);
   endtask

   initial begin
      logic [15:0] phase_len[4];
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: a first sample, zero and unit lengths, then the field extremes.
      offer_point(32'd100, 32'd0, 32'd0, 32'd0, 1'b0);
      offer_point(32'd100, 32'd0, 32'd0, 32'd5, 1'b0);
      offer_point(32'd101, 32'd0, 32'd0, 32'd6, 1'b0);
      offer_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 1'b1);
      offer_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      offer_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1234_5678, 1'b0);
      offer_point(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      offer_point(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      offer_point(32'h0, 32'hFFFF_FFFF, 32'h0, 32'h1, 1'b0);
      offer_point(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h2, 1'b0);
      offer_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h3, 1'b1);
      offer_point(32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h4, 1'b0);

      // Minimum length at its top: short and just-long-enough segments.
      write_min_length(16'hFFFF);
      offer_point(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
      offer_point(32'h0000_FFFE, 32'h0, 32'h0, 32'h1, 1'b0);
      offer_point(32'h0001_FFFD, 32'h0, 32'h0, 32'h2, 1'b0);
      offer_point(32'h0001_FFFD, 32'h0001_0000, 32'h0, 32'h3, 1'b0);

      // Minimum length zero: only zero-length segments are dropped.
      write_min_length(16'h0000);
      offer_point(32'h5, 32'h5, 32'h5, 32'h0, 1'b0);
      offer_point(32'h5, 32'h5, 32'h5, 32'h0, 1'b0);
      offer_point(32'h5, 32'h6, 32'h5, 32'h0, 1'b0);

      // Random phases under a few settings, with a calm stretch in the middle.
      phase_len[0] = 16'd1;
      phase_len[1] = 16'd200;
      phase_len[2] = 16'd0;
      phase_len[3] = 16'hFFFF;
      for (int p = 0; p < 4; p++) begin
         write_min_length(phase_len[p]);
         for (int i = 0; i < 65; i++) begin
            calm_stretch = (p == 2 && i >= 10 && i < 40);
            random_sample();
         end
      end
      calm_stretch = 1'b0;
      stimulus_done = 1'b1;
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d samples, %0d ribbon segments, %0d vertices checked",
               sample_count, segment_count, vertex_count);
      $display("minimum length settings 0, 1, 200 and 65535; long result hold-off applied");
      if (fail_count == 0)
         $display("line_ribbon_quad_expander_top verification clean");
      else
         $display("line_ribbon_quad_expander_top verification failed");
      $finish;
   end
endmodule
